@@ src/sba_pkg.sv @@
// Shared types and constants for the slab bitmap allocator.
// Used by the channel interfaces, the allocator modules and the checker.
package sba_pkg;

	localparam int SLAB_CAP = 64;
	localparam int SLAB_W   = 6;
	localparam int SLOT_W   = 6;
	localparam int HANDLE_W = 12;
	localparam int SIU_W    = 7;

	localparam logic MODE_ALLOC = 1'b0;
	localparam logic MODE_FREE  = 1'b1;

	localparam logic [1:0] STAT_OK         = 2'd0;
	localparam logic [1:0] STAT_NO_SPACE   = 2'd1;
	localparam logic [1:0] STAT_BAD_HANDLE = 2'd2;

	typedef struct packed {
		logic                mode;
		logic [HANDLE_W-1:0] handle;
	} req_t;

	typedef struct packed {
		logic [HANDLE_W-1:0] slot_handle;
		logic [1:0]          status;
	} rsp_t;

	typedef struct packed {
		logic              found;
		logic [SLAB_W-1:0] idx;
	} ffs_res_t;

	typedef struct packed {
		logic              rd_en;
		logic [SLAB_W-1:0] rd_addr;
		logic              wr_en;
		logic [SLAB_W-1:0] wr_addr;
	} ram_ctl_t;

endpackage

@@ src/sba_if.sv @@
// Valid/ready channel interfaces for allocator requests and responses.
// Depends on sba_pkg for the payload types.
interface sba_req_if;
	import sba_pkg::*;
	logic valid;
	logic ready;
	req_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface sba_rsp_if;
	import sba_pkg::*;
	logic valid;
	logic ready;
	rsp_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

@@ src/slab_bitmap_allocator.sv @@
// Slab bitmap slot allocator, one request at a time under a small sequencer.
// An allocate reads the open slab, sets its first free bit and, if the slab
// fills, seeks the next open slab; a free clears the bit, a bad free is refused.
// A new request is taken only once the last result is registered; the two
// searches share the find-first-set unit. Reset clears control state at once.
module slab_bitmap_allocator #(
	parameter int SLOTS_PER_SLAB = 64,
	parameter int MAX_SLABS      = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	sba_req_if.sink      req,
	sba_rsp_if.source    rsp
);
	import sba_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_A_RD,
		S_A_SET,
		S_A_SCAN,
		S_F_RD,
		S_OUT
	} state_t;

	localparam logic [SIU_W-1:0] MAX_SLABS_C = SIU_W'(MAX_SLABS);
	localparam logic [SIU_W-1:0] SLOTS_C     = SIU_W'(SLOTS_PER_SLAB);

	state_t                    state_q;
	logic [SLAB_W-1:0]         slab_q;
	logic [SLOT_W-1:0]         bit_q;
	logic [SLAB_W-1:0]         first_open_q;
	logic [SIU_W-1:0]          slabs_in_use_q;
	logic [SLAB_CAP-1:0]       full_q;
	rsp_t                      res_q;
	logic                      out_valid_q;
	rsp_t                      out_q;

	ram_ctl_t                  ram_ctl;
	logic [SLOTS_PER_SLAB-1:0] rdata;
	logic [SLOTS_PER_SLAB-1:0] wdata;
	logic [SLOTS_PER_SLAB-1:0] free_bits;
	logic [SLOTS_PER_SLAB-1:0] word_set;
	logic [SLOTS_PER_SLAB-1:0] word_clr;
	logic                      full_new;
	logic [SLAB_CAP-1:0]       slab_vec;
	logic [SLAB_CAP-1:0]       ffs_vec;
	logic                      ffs_load;
	ffs_res_t                  ffs;

	logic                      req_fire;
	logic [SLAB_W-1:0]         h_slab;
	logic [SLOT_W-1:0]         h_bit;
	logic                      h_bad;

	assign req.ready   = (state_q == S_IDLE);
	assign req_fire    = req.valid && req.ready;
	assign h_slab      = req.payload.handle[HANDLE_W-1:SLOT_W];
	assign h_bit       = req.payload.handle[SLOT_W-1:0];
	assign h_bad       = (SIU_W'(h_slab) >= slabs_in_use_q) || (SIU_W'(h_bit) >= SLOTS_C);

	assign free_bits = ~rdata;
	assign word_set  = rdata | (SLOTS_PER_SLAB'(1) << ffs.idx);
	assign word_clr  = rdata & ~(SLOTS_PER_SLAB'(1) << bit_q);
	assign full_new  = &word_set;

	// Candidates for the next open slab: not full, above the current one, opened.
	always_comb begin
		for (int i = 0; i < SLAB_CAP; i++) begin
			slab_vec[i] = !full_q[i] && (SIU_W'(i) > SIU_W'(slab_q))
				&& (SIU_W'(i) < slabs_in_use_q);
		end
	end

	assign ffs_vec  = (state_q == S_A_RD) ? SLAB_CAP'(free_bits) : slab_vec;
	assign ffs_load = (state_q == S_A_RD) || (state_q == S_A_SET && ffs.found && full_new);

	always_comb begin
		ram_ctl.rd_en   = req_fire && !(req.payload.mode == MODE_FREE && h_bad);
		ram_ctl.rd_addr = (req.payload.mode == MODE_ALLOC) ? first_open_q : h_slab;
		ram_ctl.wr_en   = (state_q == S_A_SET && ffs.found) || (state_q == S_F_RD);
		ram_ctl.wr_addr = slab_q;
	end

	assign wdata = (state_q == S_F_RD) ? word_clr : word_set;

	sba_ram #(.WIDTH(SLOTS_PER_SLAB)) u_ram (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ram_ctl),
		.wdata  (wdata),
		.rdata  (rdata)
	);

	sba_ffs u_ffs (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (ffs_load),
		.vec    (ffs_vec),
		.res    (ffs)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			slab_q         <= '0;
			bit_q          <= '0;
			first_open_q   <= '0;
			slabs_in_use_q <= SIU_W'(1);
			full_q         <= '0;
			res_q          <= '0;
			out_valid_q    <= 1'b0;
			out_q          <= '0;
		end else begin
			// In S_OUT the output register is handled by that state alone.
			if (rsp.ready && state_q != S_OUT) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_fire) begin
						if (req.payload.mode == MODE_ALLOC) begin
							slab_q  <= first_open_q;
							state_q <= S_A_RD;
						end else if (h_bad) begin
							res_q   <= '{slot_handle: '0, status: STAT_BAD_HANDLE};
							state_q <= S_OUT;
						end else begin
							slab_q  <= h_slab;
							bit_q   <= h_bit;
							state_q <= S_F_RD;
						end
					end
				end
				S_A_RD: begin
					state_q <= S_A_SET;
				end
				S_A_SET: begin
					if (!ffs.found) begin
						res_q   <= '{slot_handle: '0, status: STAT_NO_SPACE};
						state_q <= S_OUT;
					end else begin
						full_q[slab_q] <= full_new;
						res_q   <= '{slot_handle: {slab_q, ffs.idx}, status: STAT_OK};
						state_q <= full_new ? S_A_SCAN : S_OUT;
					end
				end
				S_A_SCAN: begin
					// Move to the next opened slab with room, else open one while under MAX_SLABS.
					if (ffs.found) begin
						first_open_q <= ffs.idx;
					end else if (slabs_in_use_q < MAX_SLABS_C) begin
						first_open_q   <= slabs_in_use_q[SLAB_W-1:0];
						slabs_in_use_q <= slabs_in_use_q + SIU_W'(1);
					end
					state_q <= S_OUT;
				end
				S_F_RD: begin
					full_q[slab_q] <= 1'b0;
					if (slab_q < first_open_q || full_q[first_open_q]) begin
						first_open_q <= slab_q;
					end
					res_q   <= '{slot_handle: '0, status: STAT_OK};
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (!out_valid_q || rsp.ready) begin
						out_valid_q <= 1'b1;
						out_q       <= res_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid   = out_valid_q;
	assign rsp.payload = out_q;

endmodule

@@ src/sba_ffs.sv @@
// Shared find-first-set unit with a registered result.
// Depends on sba_pkg; serves both the free-slot and the open-slab search.
module sba_ffs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           load,
	input  logic [sba_pkg::SLAB_CAP-1:0]   vec,
	output sba_pkg::ffs_res_t              res
);
	import sba_pkg::*;

	ffs_res_t res_c;
	ffs_res_t res_q;

	always_comb begin
		res_c = '0;
		for (int i = SLAB_CAP - 1; i >= 0; i--) begin
			if (vec[i]) begin
				res_c.found = 1'b1;
				res_c.idx   = SLAB_W'(i);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_q <= '0;
		end else if (load) begin
			res_q <= res_c;
		end
	end

	assign res = res_q;

endmodule

@@ src/sba_ram.sv @@
// Slab occupancy bitmap memory: one write port, one registered read port.
// Per-entry valid bits make entries never written read as all free.
module sba_ram #(
	parameter int WIDTH = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  sba_pkg::ram_ctl_t    ctl,
	input  logic [WIDTH-1:0]     wdata,
	output logic [WIDTH-1:0]     rdata
);
	import sba_pkg::*;

	logic [WIDTH-1:0]    mem [SLAB_CAP];
	logic [SLAB_CAP-1:0] valid_q;
	logic [WIDTH-1:0]    rdata_q;
	logic                rd_valid_q;

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[ctl.wr_addr] <= wdata;
		end
		if (ctl.rd_en) begin
			rdata_q <= mem[ctl.rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (ctl.wr_en) begin
				valid_q[ctl.wr_addr] <= 1'b1;
			end
			if (ctl.rd_en) begin
				rd_valid_q <= valid_q[ctl.rd_addr];
			end
		end
	end

	assign rdata = rd_valid_q ? rdata_q : '0;

endmodule

@@ src/sba_checker.sv @@
// Port-level checker for the slab bitmap allocator, bound to the top level.
// Depends on sba_pkg for the status codes.
module sba_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         req_valid,
	input logic                         req_ready,
	input logic                         rsp_valid,
	input logic                         rsp_ready,
	input logic [sba_pkg::HANDLE_W-1:0] rsp_slot_handle,
	input logic [1:0]                   rsp_status
);
	import sba_pkg::*;

	// A held result stays offered until it is taken.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result dropped before it was taken");

	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(rsp_slot_handle) && $stable(rsp_status))
		else $error("result payload changed while stalled");

	// Only one item is worked on at a time.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("new item accepted while one is in progress");

	// A failed request never carries a slot handle.
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status != STAT_OK |-> rsp_slot_handle == '0)
		else $error("failed request returned a nonzero handle");

endmodule

bind slab_bitmap_allocator sba_checker u_sba_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.req_valid       (req.valid),
	.req_ready       (req.ready),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.rsp_slot_handle (rsp.payload.slot_handle),
	.rsp_status      (rsp.payload.status)
);
